// ----- rtl/srtf_pkg.sv -----
// Shared types and constants for the SRTF scheduler.
package srtf_pkg;

	localparam int ID_W   = 8;
	localparam int ARR_W  = 16;
	localparam int REM_W  = 16;
	localparam int PC_W   = 5;
	localparam int SLOT_W = 4;
	localparam int TT_W   = 16;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef struct packed {
		logic              cmd;
		logic [SLOT_W-1:0] slot;
		logic [ID_W-1:0]   process_id;
		logic [ARR_W-1:0]  arrival;
		logic [REM_W-1:0]  burst;
	} req_t;

	typedef struct packed {
		logic              idle;
		logic [SLOT_W-1:0] chosen_slot;
		logic [ID_W-1:0]   chosen_id;
		logic              switched;
		logic [TT_W-1:0]   tick_time;
	} rsp_t;

	typedef struct packed {
		logic [ID_W-1:0]  id;
		logic [ARR_W-1:0] arr;
		logic [REM_W-1:0] rem;
	} entry_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FIN
	} state_t;

endpackage

// ----- rtl/srtf_scheduler.sv -----
// Top level of the shortest-remaining-time-first scheduler.
//
// Requests enter on req when start is high and busy is low. A load request
// writes one task slot (id, arrival, burst) in the accept cycle and returns
// no result; busy stays low, so loads can follow back to back. A tick request
// scans slots 0 .. min(process_count, SLOTS)-1 one entry per cycle from a
// single task RAM (registered read), keeps the running best in registers,
// then writes the decremented remaining time back to the winning slot.
// A tick goes from accept through the scan and finish states to its result;
// the next request is taken in the cycle the result is shown. The result
// sits on rsp for exactly one cycle marked by done; the receiver cannot
// stall it.
// process_count is written on the cfg channel (always ready) and must only
// change while no tick is in flight.
// Reset clears the time counter, the previous id, process_count and the
// control state; the task RAM holds no reset value and every slot in use
// must be loaded before a tick scans it.
module srtf_scheduler #(
	parameter int SLOTS     = 16,
	parameter int TIME_BITS = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	output logic                   busy,
	input  srtf_pkg::req_t         req,
	output logic                   done,
	output srtf_pkg::rsp_t         rsp,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [srtf_pkg::PC_W-1:0] cfg_data
);

	import srtf_pkg::*;

	localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CW = $clog2(SLOTS + 1);
	localparam int EW = $bits(entry_t);

	state_t state_q, state_d;

	logic [PC_W-1:0]      pc_q;
	logic [TIME_BITS-1:0] cur_q;
	logic [ID_W-1:0]      prev_q;
	logic [CW-1:0]        rd_idx_q, lim_q;
	logic                 vld_s1;
	logic [AW-1:0]        idx_s1;
	logic                 found_q;
	logic [AW-1:0]        best_idx_q;
	entry_t               best_q;
	logic                 done_q;
	rsp_t                 rsp_q;

	logic accept, is_load, is_tick, load_ok;
	logic rd_en, in_scan, in_fin;
	logic scan_end;
	logic [31:0] slot_w, lim_w, cur_w, best_slot_w;
	logic [CW-1:0] lim_c;
	entry_t rd_e, wr_e, ld_e;
	logic [EW-1:0] rdata, wdata;
	logic we;
	logic [AW-1:0] waddr;
	logic elig, better;

	assign accept  = start && !busy;
	assign is_load = accept && (req.cmd == CMD_LOAD);
	assign is_tick = accept && (req.cmd == CMD_TICK);
	assign slot_w  = 32'(req.slot);
	assign load_ok = is_load && (slot_w < 32'(SLOTS));
	assign lim_w   = (32'(pc_q) < 32'(SLOTS)) ? 32'(pc_q) : 32'(SLOTS);
	assign lim_c   = lim_w[CW-1:0];
	assign cur_w   = 32'(cur_q);
	assign best_slot_w = 32'(best_idx_q);
	assign cfg_ready = 1'b1;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (is_tick) begin
					state_d = ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (scan_end) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN:  state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// fsm outputs
	always_comb begin
		busy    = 1'b1;
		in_scan = 1'b0;
		in_fin  = 1'b0;
		case (state_q)
			ST_IDLE: busy = 1'b0;
			ST_SCAN: in_scan = 1'b1;
			ST_FIN:  in_fin = 1'b1;
			default: busy = 1'b1;
		endcase
	end

	assign rd_en    = in_scan && (rd_idx_q < lim_q);
	assign scan_end = (rd_idx_q == lim_q) && !vld_s1;

	assign rd_e = entry_t'(rdata);
	assign elig = vld_s1 && (rd_e.rem != '0) && (32'(rd_e.arr) <= cur_w);
	assign better = !found_q || (rd_e.rem < best_q.rem) ||
		((rd_e.rem == best_q.rem) && (rd_e.arr < best_q.arr));

	always_comb begin
		ld_e.id  = req.process_id;
		ld_e.arr = req.arrival;
		ld_e.rem = req.burst;
		wr_e     = best_q;
		wr_e.rem = best_q.rem - REM_W'(1);
	end

	assign we    = load_ok || (in_fin && found_q);
	assign waddr = in_fin ? best_idx_q : slot_w[AW-1:0];
	assign wdata = in_fin ? EW'(wr_e) : EW'(ld_e);

	srtf_ram #(
		.WIDTH(EW),
		.DEPTH(SLOTS)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (rd_en),
		.raddr(rd_idx_q[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			pc_q     <= '0;
			cur_q    <= '0;
			prev_q   <= '0;
			rd_idx_q <= '0;
			lim_q    <= '0;
			vld_s1   <= 1'b0;
			found_q  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= in_fin;
			vld_s1  <= rd_en;
			if (cfg_valid && cfg_ready) begin
				pc_q <= cfg_data;
			end
			if (is_tick) begin
				rd_idx_q <= '0;
				lim_q    <= lim_c;
				found_q  <= 1'b0;
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + CW'(1);
			end
			if (elig && better) begin
				found_q <= 1'b1;
			end
			if (in_fin) begin
				cur_q <= cur_q + TIME_BITS'(1);
				if (found_q) begin
					prev_q <= best_q.id;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q[AW-1:0];
		if (elig && better) begin
			best_q     <= rd_e;
			best_idx_q <= idx_s1;
		end
		if (in_fin) begin
			rsp_q.idle        <= !found_q;
			rsp_q.chosen_slot <= found_q ? best_slot_w[SLOT_W-1:0] : '0;
			rsp_q.chosen_id   <= found_q ? best_q.id : '0;
			rsp_q.switched    <= found_q && (best_q.id != prev_q);
			rsp_q.tick_time   <= cur_w[TT_W-1:0];
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

endmodule

// ----- rtl/srtf_ram.sv -----
// Generic simple dual-port RAM with registered read.
module srtf_ram #(
	parameter int WIDTH = 40,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ----- rtl/srtf_chk.sv -----
// Port-level checker for the SRTF scheduler, bound to the top level.
module srtf_chk (
	input logic           clk,
	input logic           arst_n,
	input logic           start,
	input logic           busy,
	input logic           done,
	input srtf_pkg::req_t req,
	input srtf_pkg::rsp_t rsp
);

	import srtf_pkg::*;

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("done held longer than one cycle");

	a_load_no_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_LOAD) |=> !busy && !done)
		else $error("load request made the block busy or gave a result");

	a_tick_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && req.cmd == CMD_TICK) |=> busy)
		else $error("tick request did not start a scan");

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result without a tick in flight");

	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.idle) |-> (rsp.chosen_id == '0 && rsp.chosen_slot == '0
			&& !rsp.switched))
		else $error("idle result carries a choice");

endmodule

bind srtf_scheduler srtf_chk u_chk (.*);
